[design/wtt_pkg.sv]
// Shared types and constants for the Winograd F(2x2,3x3) input tile transform.
package wtt_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_PIXEL_BITS = 16;

    // Fixed field widths
    localparam int HALF_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TILE_W    = 7;
    localparam int IDX_W     = 4;
    localparam int TILE_DIM  = 4;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_HALF_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS = 2'd1;
    localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd128;
    localparam logic [HALF_W-1:0]    HALF_MIN      = 8'd2;

    // Index of the final coefficient of a tile
    localparam logic [IDX_W-1:0] LAST_COEF = 4'd15;

    // Tile position that travels with a tile from the window to the serializer
    typedef struct packed {
        logic [TILE_W-1:0] tile_row;
        logic [TILE_W-1:0] tile_col;
    } tile_meta_t;

endpackage

[design/winograd_f2x3_input_tile_transform_top.sv]
// Top level of the Winograd F(2x2,3x3) input tile transform over a raster pixel stream.
//
// Usage:
//   Pixels of one plane enter in raster order on pixel/pixel_valid/pixel_stall; a
//   transfer happens at a clock edge with valid high and stall low. Every pixel at
//   an odd row and odd column, both three or more, completes a 4x4 tile at stride 2,
//   and the block sends the 16 values of B^T d B on the result channel
//   (result_valid/result_stall), row-major, with tile position and coef_index;
//   last marks coefficient 15.
//   The first coefficient of a tile passes from the pixel stage register through the
//   tile buffer into the output register; the rest follow one per cycle while the
//   result side does not stall. A pixel that completes no tile never holds up the
//   input, so on rows without tiles the block takes a pixel every cycle. On tile
//   rows the single result register sets the pace. One tile drains from the buffer
//   while the next waits in the pixel stage. The line store is four single-port-write
//   RAMs, one per row slot, read at the current column on each pixel transfer.
//   Reset clears the counters, sets both sizes to 128 and empties the pipeline;
//   the line store is not cleared and needs no clearing pass. A stall on the result
//   side holds the output register; once the tile buffer is full pixel_stall rises.
//   The cfg port (always ready) writes half_cols (index 0) or half_rows (index 1)
//   and restarts the plane; write it only while idle.
module winograd_f2x3_input_tile_transform_top #(
    parameter int MAX_COLS   = wtt_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = wtt_pkg::DEF_MAX_ROWS,
    parameter int PIXEL_BITS = wtt_pkg::DEF_PIXEL_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wtt_pkg::HALF_W-1:0]     cfg_data,
    // pixel channel
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic signed [PIXEL_BITS-1:0]   pixel,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [PIXEL_BITS+1:0]   coefficient,
    output logic [wtt_pkg::IDX_W-1:0]      coef_index,
    output logic [wtt_pkg::TILE_W-1:0]     tile_row,
    output logic [wtt_pkg::TILE_W-1:0]     tile_col,
    output logic                           last
);
    import wtt_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CMP_C = ((HALF_W > CW) ? HALF_W : CW) + 1;
    localparam int CMP_R = ((HALF_W > RW) ? HALF_W : RW) + 1;
    localparam logic [CMP_C-1:0] TOP_C = CMP_C'(MAX_COLS / 2);
    localparam logic [CMP_R-1:0] TOP_R = CMP_R'(MAX_ROWS / 2);

    // Configuration and position
    logic [HALF_W-1:0] half_cols_reg;
    logic [HALF_W-1:0] half_rows_reg;
    logic [CW-1:0]     col_pos_reg;
    logic [RW-1:0]     row_pos_reg;
    logic [CW-1:0]     col_pos_next;
    logic [RW-1:0]     row_pos_next;
    logic              cfg_write;

    // Stage after pixel transfer
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic signed [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [1:0]                   s1_slot_reg;
    logic                         s1_emit_reg;
    tile_meta_t                   s1_meta_reg;
    logic                         s1_go;

    // Column window, three stored columns by four rows; the fourth column is col_vec
    logic signed [PIXEL_BITS-1:0] win_reg [TILE_DIM-1][TILE_DIM];
    logic signed [PIXEL_BITS-1:0] col_vec [TILE_DIM];
    logic signed [PIXEL_BITS-1:0] tile_d  [TILE_DIM][TILE_DIM];

    logic [PIXEL_BITS-1:0] ram_q [TILE_DIM];
    logic                  accept;
    logic                  tile_hit;
    logic                  ser_ready;
    logic [CMP_C-1:0]      half_c_eff;
    logic [CMP_R-1:0]      half_r_eff;
    logic [CMP_C-1:0]      col_lim;
    logic [CMP_R-1:0]      row_lim;
    logic [CMP_C-1:0]      col_inc;
    logic [CMP_R-1:0]      row_inc;
    logic [CW:0]           col_off;
    logic [RW:0]           row_off;
    tile_meta_t            hit_meta;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_cols_reg <= HALF_RESET;
            half_rows_reg <= HALF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_COLS: half_cols_reg <= cfg_data;
                REG_HALF_ROWS: half_rows_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Clamp sizes to [2, MAX/2] and find the plane edges
    always_comb
    begin
        if (half_cols_reg < HALF_MIN)
            half_c_eff = CMP_C'(HALF_MIN);
        else if (CMP_C'(half_cols_reg) > TOP_C)
            half_c_eff = TOP_C;
        else
            half_c_eff = CMP_C'(half_cols_reg);

        if (half_rows_reg < HALF_MIN)
            half_r_eff = CMP_R'(HALF_MIN);
        else if (CMP_R'(half_rows_reg) > TOP_R)
            half_r_eff = TOP_R;
        else
            half_r_eff = CMP_R'(half_rows_reg);

        col_lim = half_c_eff << 1;
        row_lim = half_r_eff << 1;
        col_inc = CMP_C'(col_pos_reg) + CMP_C'(1);
        row_inc = CMP_R'(row_pos_reg) + CMP_R'(1);
    end

    // Position counters with wrap at row and plane end
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (cfg_write && (cfg_index == REG_HALF_COLS || cfg_index == REG_HALF_ROWS))
        begin
            col_pos_next = '0;
            row_pos_next = '0;
        end
        else if (accept)
        begin
            if (col_inc >= col_lim)
            begin
                col_pos_next = '0;
                row_pos_next = (row_inc >= row_lim) ? '0 : RW'(row_inc);
            end
            else
            begin
                col_pos_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // Tile detection and tile position
    always_comb
    begin
        tile_hit = row_pos_reg[0] && col_pos_reg[0] &&
                   (row_pos_reg >= RW'(3)) && (col_pos_reg >= CW'(3));
        row_off  = {1'b0, row_pos_reg} - (RW+1)'(3);
        col_off  = {1'b0, col_pos_reg} - (CW+1)'(3);
        hit_meta.tile_row = TILE_W'(row_off >> 1);
        hit_meta.tile_col = TILE_W'(col_off >> 1);
    end

    // Pixel handshake
    assign s1_go       = s1_valid_reg && (!s1_emit_reg || ser_ready);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_slot_reg  <= row_pos_reg[1:0];
            s1_emit_reg  <= tile_hit;
            s1_meta_reg  <= hit_meta;
        end
    end

    // Line store: one RAM per row slot, read at the current column
    for (genvar i = 0; i < TILE_DIM; i++)
    begin : g_line
        wtt_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_COLS)
        ) u_line (
            .clk   (clk),
            .we    (accept && (row_pos_reg[1:0] == 2'(i))),
            .waddr (col_pos_reg),
            .wdata (pixel),
            .re    (accept),
            .raddr (col_pos_reg),
            .rdata (ram_q[i])
        );
    end

    // Column of rows r-3..r; the current row comes from the pixel register
    always_comb
    begin
        for (int a = 0; a < TILE_DIM - 1; a++)
        begin
            col_vec[a] = $signed(ram_q[2'(s1_slot_reg + 2'(a + 1))]);
        end
        col_vec[TILE_DIM-1] = s1_pixel_reg;
    end

    // Window shift on each stage transfer
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            for (int b = 0; b < TILE_DIM - 2; b++)
            begin
                win_reg[b] <= win_reg[b+1];
            end
            win_reg[TILE_DIM-2] <= col_vec;
        end
    end

    // Tile as d[row][col]
    always_comb
    begin
        for (int a = 0; a < TILE_DIM; a++)
        begin
            for (int b = 0; b < TILE_DIM - 1; b++)
            begin
                tile_d[a][b] = win_reg[b][a];
            end
            tile_d[a][TILE_DIM-1] = col_vec[a];
        end
    end

    wtt_coef_serializer #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (s1_valid_reg && s1_emit_reg),
        .load_ready   (ser_ready),
        .tile_d       (tile_d),
        .load_meta    (s1_meta_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .coefficient  (coefficient),
        .coef_index   (coef_index),
        .tile_row     (tile_row),
        .tile_col     (tile_col),
        .last         (last)
    );

    // Pixels are held back only by a completed tile waiting for the buffer
    a_stall_only_on_tile: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (s1_valid_reg && s1_emit_reg && !ser_ready))
        else $error("pixel stall without a waiting tile");

    // A size write restarts the plane
    a_cfg_restarts_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == REG_HALF_COLS || cfg_index == REG_HALF_ROWS))
        |=> ((col_pos_reg == '0) && (row_pos_reg == '0)))
        else $error("size write did not clear the position counters");

    // Position counters stay inside the configured plane
    a_pos_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_C'(col_pos_reg) < col_lim) && (CMP_R'(row_pos_reg) < row_lim))
        else $error("position counter outside the plane");

endmodule

[design/wtt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/wtt_coef_serializer.sv]
// Row transform of one 4x4 tile, then column transform; one coefficient per cycle unless stalled.
module wtt_coef_serializer #(
    parameter int PIXEL_BITS = wtt_pkg::DEF_PIXEL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tile load side
    input  logic                          load_valid,
    output logic                          load_ready,
    input  logic signed [PIXEL_BITS-1:0]  tile_d [wtt_pkg::TILE_DIM][wtt_pkg::TILE_DIM],
    input  wtt_pkg::tile_meta_t           load_meta,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [PIXEL_BITS+1:0]  coefficient,
    output logic [wtt_pkg::IDX_W-1:0]     coef_index,
    output logic [wtt_pkg::TILE_W-1:0]    tile_row,
    output logic [wtt_pkg::TILE_W-1:0]    tile_col,
    output logic                          last
);
    import wtt_pkg::*;

    localparam int UW = PIXEL_BITS + 1;
    localparam int VW = PIXEL_BITS + 2;

    // Tile buffer: B^T d held while its 16 coefficients go out
    logic signed [UW-1:0] u_reg [TILE_DIM][TILE_DIM];
    logic signed [UW-1:0] u_next [TILE_DIM][TILE_DIM];
    logic                 buf_valid_reg;
    logic [IDX_W-1:0]     k_reg;
    tile_meta_t           meta_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [VW-1:0] coef_reg;
    logic [IDX_W-1:0]     idx_reg;
    tile_meta_t           out_meta_reg;
    logic                 last_reg;

    logic                 out_load;
    logic                 emit;
    logic                 load;
    logic signed [UW-1:0] ua [TILE_DIM];
    logic signed [VW-1:0] v_sel;

    // Row combination B^T d, all four columns at once
    always_comb
    begin
        for (int b = 0; b < TILE_DIM; b++)
        begin
            u_next[0][b] = UW'(tile_d[0][b]) - UW'(tile_d[2][b]);
            u_next[1][b] = UW'(tile_d[1][b]) + UW'(tile_d[2][b]);
            u_next[2][b] = UW'(tile_d[2][b]) - UW'(tile_d[1][b]);
            u_next[3][b] = UW'(tile_d[1][b]) - UW'(tile_d[3][b]);
        end
    end

    // Column combination for the current coefficient
    always_comb
    begin
        for (int b = 0; b < TILE_DIM; b++)
        begin
            ua[b] = u_reg[k_reg[3:2]][b];
        end
        case (k_reg[1:0])
            2'd0:    v_sel = VW'(ua[0]) - VW'(ua[2]);
            2'd1:    v_sel = VW'(ua[1]) + VW'(ua[2]);
            2'd2:    v_sel = VW'(ua[2]) - VW'(ua[1]);
            default: v_sel = VW'(ua[1]) - VW'(ua[3]);
        endcase
    end

    // Handshake: output reg refills when empty or taken
    assign out_load   = !out_valid_reg || !result_stall;
    assign emit       = buf_valid_reg && out_load;
    assign load_ready = !buf_valid_reg || (emit && (k_reg == LAST_COEF));
    assign load       = load_valid && load_ready;

    // Tile buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else if (load)
        begin
            buf_valid_reg <= 1'b1;
            k_reg         <= '0;
        end
        else if (emit)
        begin
            if (k_reg == LAST_COEF)
            begin
                buf_valid_reg <= 1'b0;
            end
            k_reg <= k_reg + IDX_W'(1);
        end
    end

    // Tile buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u_reg    <= u_next;
            meta_reg <= load_meta;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= buf_valid_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            coef_reg     <= v_sel;
            idx_reg      <= k_reg;
            out_meta_reg <= meta_reg;
            last_reg     <= (k_reg == LAST_COEF);
        end
    end

    assign result_valid = out_valid_reg;
    assign coefficient  = coef_reg;
    assign coef_index   = idx_reg;
    assign tile_row     = out_meta_reg.tile_row;
    assign tile_col     = out_meta_reg.tile_col;
    assign last         = last_reg;

    // A tile part way out always has its previous coefficient in the output register
    a_partial_tile_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && (k_reg != '0)) |-> out_valid_reg)
        else $error("tile buffer advanced without a coefficient in the output register");

    // The buffer only empties after its last coefficient moved out
    a_buffer_frees_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(buf_valid_reg) |-> ($past(k_reg) == LAST_COEF))
        else $error("tile buffer released before coefficient 15");

    // A new tile is never loaded over one that still has coefficients to send
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && buf_valid_reg) |-> (emit && (k_reg == LAST_COEF)))
        else $error("tile buffer overwritten");

endmodule

[tb/tb_winograd_f2x3_input_tile_transform_top.sv]
// Self-checking testbench for the Winograd F(2x2,3x3) input tile transform top level.
module tb_winograd_f2x3_input_tile_transform_top;
    import wtt_pkg::*;

    localparam int PIX_W         = DEF_PIXEL_BITS;
    localparam int COEF_W        = DEF_PIXEL_BITS + 2;
    localparam int HALF_TOP_COLS = DEF_MAX_COLS / 2;
    localparam int HALF_TOP_ROWS = DEF_MAX_ROWS / 2;
    localparam int RANDOM_ITEMS  = 180;
    localparam int EDGE_PIXELS   = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PARTIAL_CAP   = 96;

    // Register indexes past the map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic [IDX_W-1:0]         index;
        tile_meta_t               pos;
        logic                     is_last;
    } coef_rec_t;

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [HALF_W-1:0]           cfg_data     = '0;
    logic                        pixel_valid  = 1'b0;
    logic                        pixel_stall;
    logic signed [PIX_W-1:0]     pixel        = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [COEF_W-1:0]    coefficient;
    logic [IDX_W-1:0]            coef_index;
    logic [TILE_W-1:0]           tile_row;
    logic [TILE_W-1:0]           tile_col;
    logic                        last;

    // Stimulus and expectation stores
    logic signed [PIX_W-1:0] pixel_q[$];
    coef_rec_t               coef_q[$];

    // Predictor state: line store, raster position, size registers
    logic signed [PIX_W-1:0] line_buf [4][DEF_MAX_COLS];
    int                      cur_row = 0;
    int                      cur_col = 0;
    logic [HALF_W-1:0]       width_half  = HALF_RESET;
    logic [HALF_W-1:0]       height_half = HALF_RESET;

    // Idling controls and bookkeeping
    bit calm           = 1'b0;
    bit pressure_armed = 1'b0;
    int send_gap       = 0;
    int stall_run      = 0;
    int hold_cnt       = 0;
    int idle_cycles    = 0;
    int errors         = 0;
    int pixels_sent    = 0;
    int coefs_checked  = 0;
    int tiles_checked  = 0;
    int cfg_writes     = 0;

    winograd_f2x3_input_tile_transform_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .coefficient  (coefficient),
        .coef_index   (coef_index),
        .tile_row     (tile_row),
        .tile_col     (tile_col),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Size register as the block sees it: below the minimum or above the store acts as the bound
    function automatic int clamp_half(input logic [HALF_W-1:0] h, input int top);
        if (h < HALF_MIN)
            return HALF_MIN;
        if (h > top)
            return top;
        return h;
    endfunction

    // Mostly short gaps, some medium, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel values biased toward the rails and small magnitudes
    function automatic logic signed [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return PIX_W'($urandom_range(0, 16) - 8);
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // Store one pixel, emit the 16 B^T d B sums when it completes a tile, advance position
    task automatic transform_pixel(input logic signed [PIX_W-1:0] px);
        int        cols;
        int        rows;
        int        a;
        int        b;
        int        d [4][4];
        int        u [4][4];
        int        v [4];
        coef_rec_t rec;
        cols = 2 * clamp_half(width_half, HALF_TOP_COLS);
        rows = 2 * clamp_half(height_half, HALF_TOP_ROWS);
        line_buf[cur_row % 4][cur_col] = px;
        if ((cur_row % 2 == 1) && (cur_col % 2 == 1) && cur_row >= 3 && cur_col >= 3)
        begin
            for (a = 0; a < 4; a++)
                for (b = 0; b < 4; b++)
                    d[a][b] = line_buf[(cur_row - 3 + a) % 4][cur_col - 3 + b];
            // row combination
            for (b = 0; b < 4; b++)
            begin
                u[0][b] = d[0][b] - d[2][b];
                u[1][b] = d[1][b] + d[2][b];
                u[2][b] = d[2][b] - d[1][b];
                u[3][b] = d[1][b] - d[3][b];
            end
            // column combination, row-major output order
            for (a = 0; a < 4; a++)
            begin
                v[0] = u[a][0] - u[a][2];
                v[1] = u[a][1] + u[a][2];
                v[2] = u[a][2] - u[a][1];
                v[3] = u[a][1] - u[a][3];
                for (b = 0; b < 4; b++)
                begin
                    rec.coef         = COEF_W'(v[b]);
                    rec.index        = IDX_W'(a * 4 + b);
                    rec.pos.tile_row = TILE_W'((cur_row - 3) / 2);
                    rec.pos.tile_col = TILE_W'((cur_col - 3) / 2);
                    rec.is_last      = (rec.index == LAST_COEF);
                    coef_q.push_back(rec);
                end
            end
        end
        cur_col++;
        if (cur_col >= cols)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows)
                cur_row = 0;
        end
    endtask

    // Compare one result transfer with the oldest expected coefficient
    task automatic check_coef();
        coef_rec_t want;
        if (coef_q.size() == 0)
        begin
            $error("unexpected result: coefficient %0d, coef_index %0d, tile %0d/%0d",
                   coefficient, coef_index, tile_row, tile_col);
            errors++;
        end
        else
        begin
            want = coef_q.pop_front();
            if (coefficient !== want.coef)
            begin
                $error("coefficient: expected %0d, got %0d", want.coef, coefficient);
                errors++;
            end
            if (coef_index !== want.index)
            begin
                $error("coef_index: expected %0d, got %0d", want.index, coef_index);
                errors++;
            end
            if (tile_row !== want.pos.tile_row)
            begin
                $error("tile_row: expected %0d, got %0d", want.pos.tile_row, tile_row);
                errors++;
            end
            if (tile_col !== want.pos.tile_col)
            begin
                $error("tile_col: expected %0d, got %0d", want.pos.tile_col, tile_col);
                errors++;
            end
            if (last !== want.is_last)
            begin
                $error("last: expected %0d, got %0d", want.is_last, last);
                errors++;
            end
            coefs_checked++;
            if (want.is_last)
                tiles_checked++;
        end
    endtask

    // Pixel driver: predicts on each transfer, holds while stalled, inserts gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
            send_gap    = 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                transform_pixel(pixel);
                pixels_sent++;
            end
            if (pixel_valid && pixel_stall)
                ; // hold payload until taken
            else if (send_gap > 0)
            begin
                send_gap--;
                pixel_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel       <= pixel_q.pop_front();
                pixel_valid <= 1'b1;
                send_gap    = calm ? 0 : pick_gap();
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // Result monitor and receiver stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_run    = 0;
            hold_cnt     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_coef();
            // long hold-off once armed, so the tile buffer fills and the input backs up
            if (pressure_armed && result_valid)
            begin
                hold_cnt       = HOLD_CYCLES;
                pressure_armed = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_stall <= 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                result_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 20)
            begin
                stall_run = pick_gap();
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run after too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a transfer, %0d coefficients outstanding",
                     idle_cycles, coef_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One register write transfer; mirrors the effect into the predictor
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HALF_COLS:
            begin
                width_half = val;
                cur_row    = 0;
                cur_col    = 0;
            end
            REG_HALF_ROWS:
            begin
                height_half = val;
                cur_row     = 0;
                cur_col     = 0;
            end
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    // Wait until every pixel is taken and every coefficient has arrived, then let the pipe settle
    task automatic wait_drained();
        while (pixel_q.size() > 0 || pixel_valid || coef_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            pixel_q.push_back(rand_pixel());
    endtask

    // Main sequence
    initial
    begin
        int i;
        int r;
        int c;
        int n;
        int plane;
        int sel;
        int random_px;
        logic [HALF_W-1:0] odd_size;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sizes: a few pixels, no tile can complete
        queue_random(4);
        wait_drained();

        // Sizes below the minimum clamp to a 4x4 plane; rail checkerboard gives extreme sums
        cfg_write(REG_HALF_COLS, 8'd0);
        cfg_write(REG_HALF_ROWS, 8'd1);
        for (i = 0; i < 16; i++)
        begin
            r = i / 4;
            c = i % 4;
            pixel_q.push_back((((r / 2) + (c / 2)) % 2 == 0) ? 16'sh7FFF : 16'sh8000);
            // unmapped register writes mid-plane must not restart the plane
            if (i == 5)
            begin
                wait_drained();
                cfg_write(REG_SPARE_A, 8'hFF);
                cfg_write(REG_SPARE_B, 8'h00);
            end
        end
        wait_drained();

        // Widest plane (oversized value saturates): the start of its first row
        cfg_write(REG_HALF_COLS, 8'hFF);
        cfg_write(REG_HALF_ROWS, 8'd2);
        queue_random(EDGE_PIXELS);
        wait_drained();

        // Tallest plane, narrowest width, with a long output hold-off
        cfg_write(REG_HALF_COLS, 8'd2);
        cfg_write(REG_HALF_ROWS, 8'd129);
        pressure_armed = 1'b1;
        queue_random(EDGE_PIXELS);
        wait_drained();

        // Random phases: mostly whole small planes back to back, some partial and odd sizes
        random_px = 0;
        while (random_px < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            sel  = $urandom_range(0, 9);
            if (sel < 7)
            begin
                cfg_write(REG_HALF_COLS, HALF_W'($urandom_range(2, 6)));
                cfg_write(REG_HALF_ROWS, HALF_W'($urandom_range(2, 5)));
            end
            else if (sel == 7)
            begin
                case ($urandom_range(0, 4))
                    0: odd_size = 8'd0;
                    1: odd_size = 8'd1;
                    2: odd_size = HALF_RESET;
                    3: odd_size = 8'hFF;
                    default: odd_size = HALF_W'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 1) == 0)
                    cfg_write(REG_HALF_COLS, odd_size);
                else
                    cfg_write(REG_HALF_ROWS, odd_size);
            end
            else if (sel == 8)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          HALF_W'($urandom()));
            plane = 4 * clamp_half(width_half, HALF_TOP_COLS) *
                    clamp_half(height_half, HALF_TOP_ROWS);
            if ($urandom_range(0, 3) != 0)
                n = plane * $urandom_range(1, 2);
            else
                n = $urandom_range(1, plane);
            if (n > PARTIAL_CAP)
                n = PARTIAL_CAP;
            queue_random(n);
            random_px += n;
            wait_drained();
        end

        calm = 1'b0;
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (coef_q.size() != 0)
        begin
            $error("%0d expected coefficients never arrived", coef_q.size());
            errors++;
        end

        $display("Sent %0d pixels with %0d register writes; checked %0d tiles, %0d values.",
                 pixels_sent, cfg_writes, tiles_checked, coefs_checked);
        $display("Sizes from clamped 4x4 to saturated 256, plane wraps, %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/wtt_pkg.sv
design/wtt_ram.sv
design/wtt_coef_serializer.sv
design/winograd_f2x3_input_tile_transform_top.sv
tb/tb_winograd_f2x3_input_tile_transform_top.sv
